// ===== hw/rtl/wmdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed median distance filter package
// Shared types, register indexes, result codes and reset values.
// ----------------------------------------------------------------------------
package wmdf_pkg;

	localparam int TIME_W = 32;
	localparam int POS_W  = 16;
	localparam int RD_W   = 11;
	localparam int DIST_W = 10;
	localparam int BIT_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;

	localparam logic [15:0]       RST_STALE_LIMIT = 16'd500;
	localparam logic [15:0]       RST_WINDOW      = 16'd2000;
	localparam logic [7:0]        RST_MIN_VALID   = 8'd5;
	localparam logic [DIST_W-1:0] RST_MAX_DIST    = 10'd999;
	localparam logic [DIST_W-1:0] RST_TOLERANCE   = 10'd20;

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_POS  = 2'd1;
	localparam logic [1:0] STATUS_DIST = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       rd_oldest;
		logic       pop;
		logic       append;
		logic       rd_newest;
		logic       latch_pos;
		logic       sweep_start;
		logic       sweep_bwd;
		logic       sweep_run;
		logic       proc_cnt;
		logic       proc_med;
		logic       proc_choose;
		logic       med_init;
		logic       med_step;
		logic       emit;
		logic [1:0] emit_code;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic drop_old;
		logic stale;
		logic sweep_done;
		logic few_valid;
		logic bit_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/wmdf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed median distance filter channels
// Request, response and configuration write channels.
// ----------------------------------------------------------------------------
interface wmdf_req_if;
	import wmdf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [TIME_W-1:0]        now_ms;
	logic                     detected;
	logic [POS_W-1:0]         pos_x;
	logic [POS_W-1:0]         pos_y;
	logic signed [RD_W-1:0]   reading;
	modport source (output valid, func, now_ms, detected, pos_x, pos_y, reading, input ready);
	modport sink (input valid, func, now_ms, detected, pos_x, pos_y, reading, output ready);
endinterface

interface wmdf_rsp_if;
	import wmdf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [POS_W-1:0]         out_x;
	logic [POS_W-1:0]         out_y;
	logic signed [RD_W-1:0]   out_distance;
	modport source (output valid, status, out_x, out_y, out_distance, input ready);
	modport sink (input valid, status, out_x, out_y, out_distance, output ready);
endinterface

interface wmdf_cfg_if;
	import wmdf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wmdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed median distance filter controller
// Sequences pruning, appending, counting, median search and choice.
// ----------------------------------------------------------------------------
module wmdf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_func,
	output logic           in_ready,
	input  wmdf_pkg::sts_t sts,
	output wmdf_pkg::cmd_t cmd
);
	import wmdf_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DROP_RD  = 4'd1;
	localparam logic [3:0] S_DROP_CMP = 4'd2;
	localparam logic [3:0] S_APPEND   = 4'd3;
	localparam logic [3:0] S_Q_RD     = 4'd4;
	localparam logic [3:0] S_Q_STALE  = 4'd5;
	localparam logic [3:0] S_CNT      = 4'd6;
	localparam logic [3:0] S_MED      = 4'd7;
	localparam logic [3:0] S_CHOOSE   = 4'd8;
	localparam logic [3:0] S_RESULT   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= STATUS_NONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		code_d        = code_q;
		cmd           = '0;
		cmd.emit_code = code_q;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = in_func ? S_Q_RD : S_DROP_RD;
				end
			end
			S_DROP_RD: begin
				if (sts.count_zero) begin
					state_d = S_APPEND;
				end else begin
					cmd.rd_oldest = 1'b1;
					state_d       = S_DROP_CMP;
				end
			end
			S_DROP_CMP: begin
				if (sts.drop_old) begin
					cmd.pop = 1'b1;
					state_d = S_DROP_RD;
				end else begin
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = S_IDLE;
			end
			S_Q_RD: begin
				if (sts.count_zero) begin
					code_d  = STATUS_NONE;
					state_d = S_RESULT;
				end else begin
					cmd.rd_newest = 1'b1;
					state_d       = S_Q_STALE;
				end
			end
			S_Q_STALE: begin
				cmd.latch_pos = 1'b1;
				if (sts.stale) begin
					code_d  = STATUS_NONE;
					state_d = S_RESULT;
				end else begin
					cmd.sweep_start = 1'b1;
					state_d         = S_CNT;
				end
			end
			S_CNT: begin
				cmd.sweep_run = 1'b1;
				cmd.proc_cnt  = 1'b1;
				if (sts.sweep_done) begin
					if (sts.few_valid) begin
						code_d  = STATUS_POS;
						state_d = S_RESULT;
					end else begin
						cmd.med_init    = 1'b1;
						cmd.sweep_start = 1'b1;
						state_d         = S_MED;
					end
				end
			end
			S_MED: begin
				cmd.sweep_run = 1'b1;
				cmd.proc_med  = 1'b1;
				if (sts.sweep_done) begin
					cmd.med_step    = 1'b1;
					cmd.sweep_start = 1'b1;
					if (sts.bit_last) begin
						cmd.sweep_bwd = 1'b1;
						state_d       = S_CHOOSE;
					end
				end
			end
			S_CHOOSE: begin
				cmd.sweep_run   = 1'b1;
				cmd.proc_choose = 1'b1;
				if (sts.sweep_done) begin
					code_d  = STATUS_DIST;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/wmdf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed median distance filter datapath
// History ring memories, configuration registers, sweep unit and result register.
// ----------------------------------------------------------------------------
module wmdf_datapath #(
	parameter int DEPTH = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wmdf_pkg::cmd_t                  cmd,
	output wmdf_pkg::sts_t                  sts,
	input  logic [wmdf_pkg::TIME_W-1:0]     in_now_ms,
	input  logic                            in_detected,
	input  logic [wmdf_pkg::POS_W-1:0]      in_pos_x,
	input  logic [wmdf_pkg::POS_W-1:0]      in_pos_y,
	input  logic signed [wmdf_pkg::RD_W-1:0] in_reading,
	input  logic                            cfg_valid,
	input  logic [wmdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wmdf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      out_status,
	output logic [wmdf_pkg::POS_W-1:0]      out_x,
	output logic [wmdf_pkg::POS_W-1:0]      out_y,
	output logic signed [wmdf_pkg::RD_W-1:0] out_distance
);
	import wmdf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	// configuration
	logic [15:0]       stale_q, window_q;
	logic [7:0]        min_q;
	logic [DIST_W-1:0] maxd_q, tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q  <= RST_STALE_LIMIT;
			window_q <= RST_WINDOW;
			min_q    <= RST_MIN_VALID;
			maxd_q   <= RST_MAX_DIST;
			tol_q    <= RST_TOLERANCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STALE_LIMIT: stale_q  <= cfg_data;
				REG_WINDOW:      window_q <= cfg_data;
				REG_MIN_VALID:   min_q    <= cfg_data[7:0];
				REG_MAX_DIST:    maxd_q   <= cfg_data[DIST_W-1:0];
				REG_TOLERANCE:   tol_q    <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// accepted item
	logic                   det_q;
	logic [TIME_W-1:0]      now_q;
	logic [POS_W-1:0]       px_q, py_q;
	logic signed [RD_W-1:0] rdg_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			det_q <= in_detected;
			now_q <= in_now_ms;
			px_q  <= in_pos_x;
			py_q  <= in_pos_y;
			rdg_q <= in_reading;
		end
	end

	// ring pointers
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic [AW+1:0] tail_sum, newest_sum;
	logic [AW-1:0] tail_slot, newest_slot, oldest_inc;
	logic          full;

	assign full       = (count_q == CW'(DEPTH));
	assign oldest_inc = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
	assign tail_sum   = (AW+2)'(oldest_q) + (AW+2)'(count_q);
	assign newest_sum = tail_sum - 1'b1;
	assign tail_slot  = (tail_sum >= (AW+2)'(DEPTH)) ?
		AW'(tail_sum - (AW+2)'(DEPTH)) : AW'(tail_sum);
	assign newest_slot = (newest_sum >= (AW+2)'(DEPTH)) ?
		AW'(newest_sum - (AW+2)'(DEPTH)) : AW'(newest_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (cmd.pop) begin
			oldest_q <= oldest_inc;
			count_q  <= count_q - 1'b1;
		end else if (cmd.append && det_q) begin
			if (full) begin
				oldest_q <= oldest_inc;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// sweep unit
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] remain_q;
	logic          bwd_q;
	logic          pend_s1;
	logic          issue;

	assign issue = cmd.sweep_run && !cmd.sweep_start && (remain_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			remain_q <= '0;
			bwd_q    <= 1'b0;
			pend_s1  <= 1'b0;
		end else if (cmd.sweep_start) begin
			ptr_q    <= cmd.sweep_bwd ? newest_slot : oldest_q;
			remain_q <= count_q;
			bwd_q    <= cmd.sweep_bwd;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				remain_q <= remain_q - 1'b1;
				if (bwd_q) begin
					ptr_q <= (ptr_q == '0) ? LAST_SLOT : ptr_q - 1'b1;
				end else begin
					ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
				end
			end
		end
	end

	// memories
	logic [TIME_W-1:0]      time_mem [DEPTH];
	logic [POS_W-1:0]       x_mem    [DEPTH];
	logic [POS_W-1:0]       y_mem    [DEPTH];
	logic signed [RD_W-1:0] d_mem    [DEPTH];
	logic [AW-1:0]          raddr, waddr;
	logic [TIME_W-1:0]      t_rd_q;
	logic [POS_W-1:0]       x_rd_q, y_rd_q;
	logic signed [RD_W-1:0] d_rd_q;

	assign waddr = full ? oldest_q : tail_slot;

	always_comb begin
		if (cmd.rd_oldest) begin
			raddr = oldest_q;
		end else if (cmd.rd_newest) begin
			raddr = newest_slot;
		end else begin
			raddr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && det_q) begin
			time_mem[waddr] <= now_q;
			x_mem[waddr]    <= px_q;
			y_mem[waddr]    <= py_q;
			d_mem[waddr]    <= rdg_q;
		end
		t_rd_q <= time_mem[raddr];
		x_rd_q <= x_mem[raddr];
		y_rd_q <= y_mem[raddr];
		d_rd_q <= d_mem[raddr];
	end

	// ages
	logic [TIME_W-1:0] age;
	assign age = now_q - t_rd_q;

	// valid count, median bit search, choice
	logic              d_valid;
	logic [CW-1:0]     nvalid_q, less_q, mid;
	logic [DIST_W-1:0] med_q, trial;
	logic [BIT_W-1:0]  bit_q;
	logic              found_q;
	logic signed [RD_W-1:0] chosen_q;
	logic signed [RD_W:0]   diff;
	logic [RD_W:0]          adiff;
	logic                   close;
	logic [POS_W-1:0]       ox_q, oy_q;

	assign d_valid = !d_rd_q[RD_W-1] && (d_rd_q[DIST_W-1:0] <= maxd_q);
	assign mid     = nvalid_q >> 1;
	assign trial   = med_q | (DIST_W'(1) << bit_q);
	assign diff    = {d_rd_q[RD_W-1], d_rd_q} - $signed({2'b00, med_q});
	assign adiff   = diff[RD_W] ? (RD_W+1)'(-diff) : (RD_W+1)'(diff);
	assign close   = adiff < (RD_W+1)'(tol_q);

	always_ff @(posedge clk) begin
		if (cmd.latch_pos) begin
			ox_q <= x_rd_q;
			oy_q <= y_rd_q;
		end
		if (cmd.sweep_start) begin
			less_q <= '0;
		end else if (cmd.proc_med && pend_s1 && d_valid && (d_rd_q[DIST_W-1:0] < trial)) begin
			less_q <= less_q + 1'b1;
		end
		if (cmd.latch_pos) begin
			nvalid_q <= '0;
		end else if (cmd.proc_cnt && pend_s1 && d_valid) begin
			nvalid_q <= nvalid_q + 1'b1;
		end
		if (cmd.med_init) begin
			med_q <= '0;
			bit_q <= BIT_W'(DIST_W - 1);
		end else if (cmd.med_step) begin
			if (less_q <= mid) begin
				med_q <= trial;
			end
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.sweep_start) begin
			chosen_q <= -RD_W'(1);
		end else if (cmd.proc_choose && pend_s1 && !found_q && close) begin
			chosen_q <= d_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.sweep_start) begin
			found_q <= 1'b0;
		end else if (cmd.proc_choose && pend_s1 && close) begin
			found_q <= 1'b1;
		end
	end

	// result register
	logic                   ovalid_q;
	logic [1:0]             ostat_q;
	logic [POS_W-1:0]       rx_q, ry_q;
	logic signed [RD_W-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ostat_q <= cmd.emit_code;
			case (cmd.emit_code)
				STATUS_POS: begin
					rx_q <= ox_q;
					ry_q <= oy_q;
					rd_q <= -RD_W'(1);
				end
				STATUS_DIST: begin
					rx_q <= ox_q;
					ry_q <= oy_q;
					rd_q <= chosen_q;
				end
				default: begin
					rx_q <= '0;
					ry_q <= '0;
					rd_q <= '0;
				end
			endcase
		end
	end

	assign out_valid    = ovalid_q;
	assign out_status   = ostat_q;
	assign out_x        = rx_q;
	assign out_y        = ry_q;
	assign out_distance = rd_q;

	always_comb begin
		sts            = '0;
		sts.count_zero = (count_q == '0);
		sts.drop_old   = age > TIME_W'(window_q);
		sts.stale      = age > TIME_W'(stale_q);
		sts.sweep_done = found_q || ((remain_q == '0) && !pend_s1);
		sts.few_valid  = (nvalid_q == '0) || (16'(nvalid_q) < 16'(min_q));
		sts.bit_last   = (bit_q == '0);
		sts.out_free   = !ovalid_q;
	end

endmodule

// ===== hw/rtl/windowed_median_distance_filter_core.sv =====
`timescale 1ns / 1ps
// Sample item: from acceptance, the oldest entries are read and dropped while older than the
// window, then a detected sample is appended, overwriting the oldest when the history is full.
// Query: no detection when empty or stale, position only with too few valid readings, else
// the single read port gives a count, ten median and one choice pass over the history.
// One transaction at a time, the next taken the cycle after; a result waits in its register.
// Reset (arst_n low) empties the history and restores register defaults; memories keep data.
// ----------------------------------------------------------------------------
// Windowed median distance filter core
// Time-stamped target history with upper-median distance estimation.
// ----------------------------------------------------------------------------
module windowed_median_distance_filter_core #(
	parameter int HISTORY_DEPTH = 128
) (
	input logic       clk,
	input logic       arst_n,
	wmdf_req_if.sink  req,
	wmdf_rsp_if.source rsp,
	wmdf_cfg_if.sink  cfg
);
	import wmdf_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// Register writes are taken on every cycle.
	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	// Controller: one transaction in flight, sequences the sweeps.
	wmdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: ring memories, sweep counters, median search and result register.
	wmdf_datapath #(
		.DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_now_ms    (req.now_ms),
		.in_detected  (req.detected),
		.in_pos_x     (req.pos_x),
		.in_pos_y     (req.pos_y),
		.in_reading   (req.reading),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_status   (rsp.status),
		.out_x        (rsp.out_x),
		.out_y        (rsp.out_y),
		.out_distance (rsp.out_distance)
	);

`ifndef SYNTHESIS
	// Hold off the next transaction while one is being worked.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// No detection: position and distance are cleared.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_NONE) |->
		(rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_distance == '0))
		else $error("status none with non-zero payload");

	// Position only: distance reads as unreadable.
	a_pos_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_POS) |-> (rsp.out_distance == -11'sd1))
		else $error("position-only result carries a distance");
`endif

endmodule
